// ===== design/eds_pkg.sv =====
// Shared types and constants of the echo distance statistics block.
// Used by eds_unit, eds_stats and echo_distance_statistics; depends on nothing.

package eds_pkg;

    // Field and accumulator widths
    localparam int ECHO_WIDTH_BITS = 16;
    localparam int MAX_READINGS    = 256;
    localparam int CNT_W           = $clog2(MAX_READINGS);
    localparam int N_W             = CNT_W + 1;
    localparam int DIST_W          = 27;
    localparam int VAR_W           = 52;
    localparam int STD_W           = 26;
    localparam int ERR_W           = 28;
    localparam int SUM_W           = 24;
    localparam int SQSUM_W         = 40;
    localparam int SQ_W            = 2 * ECHO_WIDTH_BITS;
    localparam int NN_W            = 2 * CNT_W + 1;
    localparam int WORD_W          = 64;
    localparam int STEP_W          = 7;
    localparam int OUT_W           = DIST_W + CNT_W + DIST_W + VAR_W + STD_W + ERR_W;

    // Arithmetic constants: 0.0343 / 2 cm per us in units of 1e-5 cm, and its square
    localparam logic [10:0] DIST_PER_US    = 11'd1715;
    localparam logic [21:0] DIST_PER_US_SQ = 22'd2941225;

    // Configuration register indexes and reset values
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REFERENCE    = 2'd1;
    localparam logic [N_W-1:0]    SAMPLE_COUNT_RESET = 9'd150;
    localparam logic [DIST_W-1:0] REFERENCE_RESET    = 27'd3875000;
    localparam logic [N_W-1:0]    MAX_RUN            = N_W'(MAX_READINGS);

    // Step counts of the shared unit
    localparam logic [STEP_W-1:0] MUL_STEPS  = 7'd24;
    localparam logic [STEP_W-1:0] DIV_STEPS  = 7'd64;
    localparam logic [STEP_W-1:0] SQRT_STEPS = 7'd26;
    localparam logic [STEP_W-1:0] ALU_STEPS  = 7'd1;
    localparam int SQRT_ALIGN = WORD_W - VAR_W;

    // Operations of the shared unit
    typedef enum logic [2:0] {
        OP_MUL  = 3'd0,
        OP_DIV  = 3'd1,
        OP_SQRT = 3'd2,
        OP_ADD  = 3'd3,
        OP_SUB  = 3'd4
    } eds_op_t;

    // Command from the sequencer to the shared unit
    typedef struct packed {
        logic    start;
        eds_op_t op;
    } eds_cmd_t;

    // Number of iterations that one operation takes
    function automatic logic [STEP_W-1:0] step_limit(input eds_op_t op);
        logic [STEP_W-1:0] n;
        n = ALU_STEPS;
        unique case (op)
            OP_MUL:  n = MUL_STEPS;
            OP_DIV:  n = DIV_STEPS;
            OP_SQRT: n = SQRT_STEPS;
            default: n = ALU_STEPS;
        endcase
        return n;
    endfunction

endpackage

// ===== design/eds_unit.sv =====
// Shared iterative arithmetic unit: one 64-bit adder/subtractor used for
// shift-add multiply, restoring divide, bit-pair square root, add and subtract.
// Depends on eds_pkg.

module eds_unit (
    input  logic             aclk,
    input  logic             aresetn,
    input  eds_pkg::eds_cmd_t cmd,
    input  logic [63:0]      opnd_a,
    input  logic [63:0]      opnd_b,
    output logic             done,
    output logic [63:0]      res_main,
    output logic [63:0]      res_rem
);

    logic                        busy_reg;
    logic                        done_reg;
    eds_pkg::eds_op_t            op_reg;
    logic [eds_pkg::STEP_W-1:0]  step_reg;
    logic [63:0]                 p_reg;
    logic [63:0]                 q_reg;
    logic [63:0]                 r_reg;

    logic [63:0] shift_div;
    logic [63:0] shift_sqrt;
    logic [63:0] trial;
    logic [63:0] add_a;
    logic [63:0] add_b;
    logic        sub;
    logic [64:0] sum;
    logic        fits;
    logic        last_step;

    // Shifted partial remainders and the square root trial value
    assign shift_div  = {p_reg[62:0], q_reg[63]};
    assign shift_sqrt = {p_reg[61:0], q_reg[63:62]};
    assign trial      = {r_reg[61:0], 2'b01};

    // Operand selection for the shared adder
    always_comb begin
        add_a = '0;
        add_b = '0;
        sub   = 1'b0;
        unique case (op_reg)
            eds_pkg::OP_MUL: begin
                add_a = p_reg;
                add_b = q_reg[0] ? r_reg : '0;
            end
            eds_pkg::OP_DIV: begin
                add_a = shift_div;
                add_b = r_reg;
                sub   = 1'b1;
            end
            eds_pkg::OP_SQRT: begin
                add_a = shift_sqrt;
                add_b = trial;
                sub   = 1'b1;
            end
            eds_pkg::OP_ADD: begin
                add_a = p_reg;
                add_b = r_reg;
            end
            eds_pkg::OP_SUB: begin
                add_a = p_reg;
                add_b = r_reg;
                sub   = 1'b1;
            end
            default: begin
                add_a = '0;
            end
        endcase
    end

    // The one adder; on a subtract the carry out means no borrow.
    assign sum       = {1'b0, add_a} + {1'b0, (sub ? ~add_b : add_b)} + {64'b0, sub};
    assign fits      = sum[64];
    assign last_step = (step_reg == eds_pkg::STEP_W'(eds_pkg::step_limit(op_reg) - 7'd1));

    // Control: busy flag, step counter and completion pulse
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            op_reg   <= eds_pkg::OP_ADD;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                op_reg   <= cmd.op;
            end else if (busy_reg) begin
                step_reg <= step_reg + 7'd1;
                if (last_step) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers: loaded on a start, then one iteration per cycle
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            p_reg <= '0;
            q_reg <= '0;
            r_reg <= '0;
            unique case (cmd.op)
                eds_pkg::OP_MUL: begin
                    q_reg <= opnd_b;
                    r_reg <= opnd_a;
                end
                eds_pkg::OP_DIV: begin
                    q_reg <= opnd_a;
                    r_reg <= opnd_b;
                end
                eds_pkg::OP_SQRT: begin
                    q_reg <= opnd_a << eds_pkg::SQRT_ALIGN;
                end
                default: begin
                    p_reg <= opnd_a;
                    r_reg <= opnd_b;
                end
            endcase
        end else if (busy_reg) begin
            unique case (op_reg)
                eds_pkg::OP_MUL: begin
                    p_reg <= sum[63:0];
                    q_reg <= q_reg >> 1;
                    r_reg <= r_reg << 1;
                end
                eds_pkg::OP_DIV: begin
                    p_reg <= fits ? sum[63:0] : shift_div;
                    q_reg <= {q_reg[62:0], fits};
                end
                eds_pkg::OP_SQRT: begin
                    p_reg <= fits ? sum[63:0] : shift_sqrt;
                    r_reg <= {r_reg[62:0], fits};
                    q_reg <= q_reg << 2;
                end
                default: begin
                    p_reg <= sum[63:0];
                end
            endcase
        end
    end

    // Result selection
    always_comb begin
        unique case (op_reg)
            eds_pkg::OP_DIV:  res_main = q_reg;
            eds_pkg::OP_SQRT: res_main = r_reg;
            default:          res_main = p_reg;
        endcase
    end

    assign res_rem = p_reg;
    assign done    = done_reg;

endmodule

// ===== design/eds_stats.sv =====
// Statistics sequencer: runs mean, variance, standard deviation and mean error
// as a chain of jobs on the shared unit. Depends on eds_pkg and eds_unit.

module eds_stats (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [eds_pkg::SUM_W-1:0]   width_sum,
    input  logic [eds_pkg::SQSUM_W-1:0] width_square_sum,
    input  logic [eds_pkg::N_W-1:0]     run_length,
    input  logic [eds_pkg::DIST_W-1:0]  reference_distance,
    output logic                        done,
    output logic [eds_pkg::DIST_W-1:0]  mean_distance,
    output logic [eds_pkg::VAR_W-1:0]   variance,
    output logic [eds_pkg::STD_W-1:0]   std_dev,
    output logic [eds_pkg::ERR_W-1:0]   mean_error
);

    typedef enum logic [13:0] {
        S_IDLE    = 14'b00000000000001,
        S_MEANMUL = 14'b00000000000010,
        S_MEANDIV = 14'b00000000000100,
        S_NN      = 14'b00000000001000,
        S_NS2     = 14'b00000000010000,
        S_S1SQ    = 14'b00000000100000,
        S_DIFF    = 14'b00000001000000,
        S_QDIV    = 14'b00000010000000,
        S_QMUL    = 14'b00000100000000,
        S_RMUL    = 14'b00001000000000,
        S_RDIV    = 14'b00010000000000,
        S_VADD    = 14'b00100000000000,
        S_SQRT    = 14'b01000000000000,
        S_ERR     = 14'b10000000000000
    } stats_state_t;

    stats_state_t                  state_reg;
    stats_state_t                  state_next;
    logic                          done_reg;
    logic [eds_pkg::DIST_W-1:0]    mean_reg;
    logic [eds_pkg::NN_W-1:0]      nn_reg;
    logic [eds_pkg::NN_W-1:0]      rr_reg;
    logic [63:0]                   t_reg;
    logic [eds_pkg::VAR_W-1:0]     var_reg;
    logic [eds_pkg::STD_W-1:0]     std_reg;
    logic [eds_pkg::ERR_W-1:0]     err_reg;

    eds_pkg::eds_cmd_t cmd;
    logic [63:0]       opnd_a;
    logic [63:0]       opnd_b;
    logic              unit_done;
    logic [63:0]       res_main;
    logic [63:0]       res_rem;

    // Zero-extended operands
    logic [63:0] s1_w;
    logic [63:0] s2_w;
    logic [63:0] n_w;
    logic [63:0] nn_w;
    logic [63:0] rr_w;
    logic [63:0] k_w;
    logic [63:0] ksq_w;

    assign s1_w  = {{(64 - eds_pkg::SUM_W){1'b0}}, width_sum};
    assign s2_w  = {{(64 - eds_pkg::SQSUM_W){1'b0}}, width_square_sum};
    assign n_w   = {{(64 - eds_pkg::N_W){1'b0}}, run_length};
    assign nn_w  = {{(64 - eds_pkg::NN_W){1'b0}}, nn_reg};
    assign rr_w  = {{(64 - eds_pkg::NN_W){1'b0}}, rr_reg};
    assign k_w   = {53'b0, eds_pkg::DIST_PER_US};
    assign ksq_w = {42'b0, eds_pkg::DIST_PER_US_SQ};

    eds_unit u_unit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .opnd_a   (opnd_a),
        .opnd_b   (opnd_b),
        .done     (unit_done),
        .res_main (res_main),
        .res_rem  (res_rem)
    );

    // Job chain: each finished job but the last launches the next with its operands.
    always_comb begin
        state_next = state_reg;
        cmd.start  = 1'b0;
        cmd.op     = eds_pkg::OP_ADD;
        opnd_a     = '0;
        opnd_b     = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    state_next = S_MEANMUL;
                    cmd.start  = 1'b1;
                    cmd.op     = eds_pkg::OP_MUL;
                    opnd_a     = s1_w;
                    opnd_b     = k_w;
                end
            end
            S_MEANMUL: begin
                if (unit_done) begin
                    state_next = S_MEANDIV;
                    cmd.start  = 1'b1;
                    cmd.op     = eds_pkg::OP_DIV;
                    opnd_a     = res_main;
                    opnd_b     = n_w;
                end
            end
            S_MEANDIV: begin
                if (unit_done) begin
                    state_next = S_NN;
                    cmd.start  = 1'b1;
                    cmd.op     = eds_pkg::OP_MUL;
                    opnd_a     = n_w;
                    opnd_b     = n_w;
                end
            end
            S_NN: begin
                if (unit_done) begin
                    state_next = S_NS2;
                    cmd.start  = 1'b1;
                    cmd.op     = eds_pkg::OP_MUL;
                    opnd_a     = s2_w;
                    opnd_b     = n_w;
                end
            end
            S_NS2: begin
                if (unit_done) begin
                    state_next = S_S1SQ;
                    cmd.start  = 1'b1;
                    cmd.op     = eds_pkg::OP_MUL;
                    opnd_a     = s1_w;
                    opnd_b     = s1_w;
                end
            end
            S_S1SQ: begin
                if (unit_done) begin
                    state_next = S_DIFF;
                    cmd.start  = 1'b1;
                    cmd.op     = eds_pkg::OP_SUB;
                    opnd_a     = t_reg;
                    opnd_b     = res_main;
                end
            end
            S_DIFF: begin
                if (unit_done) begin
                    state_next = S_QDIV;
                    cmd.start  = 1'b1;
                    cmd.op     = eds_pkg::OP_DIV;
                    opnd_a     = res_main;
                    opnd_b     = nn_w;
                end
            end
            S_QDIV: begin
                if (unit_done) begin
                    state_next = S_QMUL;
                    cmd.start  = 1'b1;
                    cmd.op     = eds_pkg::OP_MUL;
                    opnd_a     = res_main;
                    opnd_b     = ksq_w;
                end
            end
            S_QMUL: begin
                if (unit_done) begin
                    state_next = S_RMUL;
                    cmd.start  = 1'b1;
                    cmd.op     = eds_pkg::OP_MUL;
                    opnd_a     = rr_w;
                    opnd_b     = ksq_w;
                end
            end
            S_RMUL: begin
                if (unit_done) begin
                    state_next = S_RDIV;
                    cmd.start  = 1'b1;
                    cmd.op     = eds_pkg::OP_DIV;
                    opnd_a     = res_main;
                    opnd_b     = nn_w;
                end
            end
            S_RDIV: begin
                if (unit_done) begin
                    state_next = S_VADD;
                    cmd.start  = 1'b1;
                    cmd.op     = eds_pkg::OP_ADD;
                    opnd_a     = t_reg;
                    opnd_b     = res_main;
                end
            end
            S_VADD: begin
                if (unit_done) begin
                    state_next = S_SQRT;
                    cmd.start  = 1'b1;
                    cmd.op     = eds_pkg::OP_SQRT;
                    opnd_a     = {{(64 - eds_pkg::VAR_W){1'b0}}, res_main[eds_pkg::VAR_W-1:0]};
                end
            end
            S_SQRT: begin
                if (unit_done) begin
                    state_next = S_ERR;
                    cmd.start  = 1'b1;
                    cmd.op     = eds_pkg::OP_SUB;
                    opnd_a     = {{(64 - eds_pkg::DIST_W){1'b0}}, mean_reg};
                    opnd_b     = {{(64 - eds_pkg::DIST_W){1'b0}}, reference_distance};
                end
            end
            S_ERR: begin
                if (unit_done) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer state and completion pulse
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= unit_done && (state_reg == S_ERR);
        end
    end

    // Keep the intermediate and final results that later jobs or the output need.
    always_ff @(posedge aclk) begin
        if (unit_done) begin
            case (state_reg)
                S_MEANDIV: mean_reg <= res_main[eds_pkg::DIST_W-1:0];
                S_NN:      nn_reg   <= res_main[eds_pkg::NN_W-1:0];
                S_NS2:     t_reg    <= res_main;
                S_QDIV:    rr_reg   <= res_rem[eds_pkg::NN_W-1:0];
                S_QMUL:    t_reg    <= res_main;
                S_VADD:    var_reg  <= res_main[eds_pkg::VAR_W-1:0];
                S_SQRT:    std_reg  <= res_main[eds_pkg::STD_W-1:0];
                S_ERR:     err_reg  <= res_main[eds_pkg::ERR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign done          = done_reg;
    assign mean_distance = mean_reg;
    assign variance      = var_reg;
    assign std_dev       = std_reg;
    assign mean_error    = err_reg;

endmodule

// ===== design/echo_distance_statistics.sv =====
// Top level of the echo distance statistics block: stream ports, configuration
// registers, per-reading distance and running sums. Depends on eds_pkg and eds_stats.

// Each echo width transfer yields one result transfer carrying the distance
// (width * 1715 in units of 1e-5 cm) and the reading's position in the run. A
// reading that is not the last of a run passes through T_MUL and T_ACC to
// T_EMIT, which loads the output register once that register is free. On the
// last reading of a run the block also works out the mean distance, the floored
// population variance, its floored square root and the mean minus the reference
// distance, on the single 64-bit add/subtract unit in eds_unit, which runs six
// 24-step multiplies, three 64-step divides, a 26-step square root and three
// adds or subtracts in turn. The input is not ready while a reading is in
// progress. The run length is sample_count, with 0 taken as 1 and values above
// 256 taken as 256; the sums clear after the last reading of each run.

module echo_distance_statistics (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration write port
    input  logic                           cfg_we,
    input  logic [eds_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [eds_pkg::DIST_W-1:0]     cfg_data,
    // Input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [15:0]                    s_axis_tdata,  // [15:0] echo_width_us
    // Result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [26:0] distance, [34:27] reading_index, [61:35] mean_distance,
    // [113:62] variance, [139:114] std_dev, [167:140] mean_error
    output logic [eds_pkg::OUT_W-1:0]      m_axis_tdata,
    output logic                           m_axis_tlast   // stats_valid
);

    typedef enum logic [5:0] {
        T_IDLE   = 6'b000001,
        T_MUL    = 6'b000010,
        T_ACC    = 6'b000100,
        T_LAUNCH = 6'b001000,
        T_STATS  = 6'b010000,
        T_EMIT   = 6'b100000
    } top_state_t;

    top_state_t                            state_reg;
    top_state_t                            state_next;
    logic [eds_pkg::N_W-1:0]               sample_count_reg;
    logic [eds_pkg::DIST_W-1:0]            reference_reg;
    logic [eds_pkg::ECHO_WIDTH_BITS-1:0]   w_reg;
    logic [eds_pkg::DIST_W-1:0]            dist_reg;
    logic [eds_pkg::SQ_W-1:0]              sq_reg;
    logic [eds_pkg::SUM_W-1:0]             s1_reg;
    logic [eds_pkg::SQSUM_W-1:0]           s2_reg;
    logic [eds_pkg::CNT_W-1:0]             count_reg;
    logic [eds_pkg::CNT_W-1:0]             idx_reg;
    logic                                  last_reg;
    logic                                  m_valid_reg;
    logic                                  m_last_reg;
    logic [eds_pkg::OUT_W-1:0]             m_data_reg;

    logic [eds_pkg::N_W-1:0]               run_length;
    logic [eds_pkg::N_W-1:0]               count_inc;
    logic                                  is_last;
    logic [eds_pkg::DIST_W-1:0]            dist_full;
    logic [eds_pkg::SQ_W-1:0]              sq_full;
    logic                                  in_xfer;
    logic                                  out_free;
    logic                                  stats_start;
    logic                                  stats_done;
    logic [eds_pkg::DIST_W-1:0]            stats_mean;
    logic [eds_pkg::VAR_W-1:0]             stats_var;
    logic [eds_pkg::STD_W-1:0]             stats_std;
    logic [eds_pkg::ERR_W-1:0]             stats_err;

    // Effective run length: zero acts as one, large values saturate.
    always_comb begin
        if (sample_count_reg == '0) begin
            run_length = eds_pkg::N_W'(1);
        end else if (sample_count_reg > eds_pkg::MAX_RUN) begin
            run_length = eds_pkg::MAX_RUN;
        end else begin
            run_length = sample_count_reg;
        end
    end

    assign count_inc = {1'b0, count_reg} + eds_pkg::N_W'(1);
    assign is_last   = (count_inc >= run_length);

    // Per-reading products
    assign dist_full = {{(eds_pkg::DIST_W - eds_pkg::ECHO_WIDTH_BITS){1'b0}}, w_reg}
                     * {{(eds_pkg::DIST_W - 11){1'b0}}, eds_pkg::DIST_PER_US};
    assign sq_full   = {{eds_pkg::ECHO_WIDTH_BITS{1'b0}}, w_reg}
                     * {{eds_pkg::ECHO_WIDTH_BITS{1'b0}}, w_reg};

    assign s_axis_tready = (state_reg == T_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign stats_start   = (state_reg == T_LAUNCH);

    eds_stats u_stats (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .start              (stats_start),
        .width_sum          (s1_reg),
        .width_square_sum   (s2_reg),
        .run_length         (run_length),
        .reference_distance (reference_reg),
        .done               (stats_done),
        .mean_distance      (stats_mean),
        .variance           (stats_var),
        .std_dev            (stats_std),
        .mean_error         (stats_err)
    );

    // Reading sequence
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            T_IDLE:   if (in_xfer) state_next = T_MUL;
            T_MUL:    state_next = T_ACC;
            T_ACC:    state_next = is_last ? T_LAUNCH : T_EMIT;
            T_LAUNCH: state_next = T_STATS;
            T_STATS:  if (stats_done) state_next = T_EMIT;
            T_EMIT:   if (out_free) state_next = T_IDLE;
            default:  state_next = T_IDLE;
        endcase
    end

    // Control registers: state, configuration, run counter, sums, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= T_IDLE;
            sample_count_reg <= eds_pkg::SAMPLE_COUNT_RESET;
            reference_reg    <= eds_pkg::REFERENCE_RESET;
            count_reg        <= '0;
            s1_reg           <= '0;
            s2_reg           <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_we) begin
                unique case (cfg_index)
                    eds_pkg::CFG_SAMPLE_COUNT: sample_count_reg <= cfg_data[eds_pkg::N_W-1:0];
                    eds_pkg::CFG_REFERENCE:    reference_reg    <= cfg_data;
                    default: begin
                    end
                endcase
            end

            if (state_reg == T_ACC) begin
                s1_reg    <= s1_reg + {{(eds_pkg::SUM_W - eds_pkg::ECHO_WIDTH_BITS){1'b0}}, w_reg};
                s2_reg    <= s2_reg + {{(eds_pkg::SQSUM_W - eds_pkg::SQ_W){1'b0}}, sq_reg};
                count_reg <= is_last ? '0 : count_inc[eds_pkg::CNT_W-1:0];
            end

            // The run's sums are cleared once the statistics have been taken.
            if ((state_reg == T_STATS) && stats_done) begin
                s1_reg <= '0;
                s2_reg <= '0;
            end

            if ((state_reg == T_EMIT) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            w_reg <= s_axis_tdata[eds_pkg::ECHO_WIDTH_BITS-1:0];
        end
        if (state_reg == T_MUL) begin
            dist_reg <= dist_full;
            sq_reg   <= sq_full;
        end
        if (state_reg == T_ACC) begin
            idx_reg  <= count_reg;
            last_reg <= is_last;
        end
        // Load the output register; statistics fields are zero off the last reading.
        if ((state_reg == T_EMIT) && out_free) begin
            m_last_reg <= last_reg;
            if (last_reg) begin
                m_data_reg <= {stats_err, stats_std, stats_var, stats_mean, idx_reg, dist_reg};
            end else begin
                m_data_reg <= {{(eds_pkg::OUT_W - eds_pkg::DIST_W - eds_pkg::CNT_W){1'b0}},
                               idx_reg, dist_reg};
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule
